>>> sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// clocked check, switched off while reset is held
`define BDSL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bdsl assertion failed");
// clocked check that also holds through reset
`define BDSL_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bdsl assertion failed");
`else
`define BDSL_ASSERT(label, clk, rst_n, prop)
`define BDSL_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> sv/bdsl_pkg.sv
package bdsl_pkg;

  // field and register widths
  localparam int TIME_W = 32;
  localparam int NOW_W  = 32;
  localparam int THR_W  = 16;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam int IDX_W  = CFG_AW - 2;

  // register reset values
  localparam logic [THR_W-1:0] DEF_WINDOW  = 16'd25;
  localparam logic [THR_W-1:0] DEF_LONG    = 16'd1000;
  localparam logic             DEF_PRESSED = 1'b0;

  // register indexes (byte address / 4)
  localparam logic [IDX_W-1:0] REG_WINDOW  = 2'd0;
  localparam logic [IDX_W-1:0] REG_LONG    = 2'd1;
  localparam logic [IDX_W-1:0] REG_PRESSED = 2'd2;

  typedef struct packed {
    logic [THR_W-1:0] window;
    logic [THR_W-1:0] long_time;
    logic             pressed_level;
  } bdsl_cfg_t;

  typedef struct packed {
    logic stage_full;
    logic armed;
    logic short_latch;
    logic long_latch;
  } bdsl_stat_t;

endpackage

>>> sv/bdsl_in_if.sv
interface bdsl_in_if;
  logic                       valid;
  logic                       ready;
  logic                       raw_level;
  logic [bdsl_pkg::NOW_W-1:0] now_ms;
  logic                       seed;
  logic                       consume_short;
  logic                       consume_long;

  modport source (output valid, raw_level, now_ms, seed, consume_short, consume_long,
                  input ready);
  modport sink (input valid, raw_level, now_ms, seed, consume_short, consume_long,
                output ready);
endinterface

>>> sv/bdsl_out_if.sv
interface bdsl_out_if;
  logic valid;
  logic ready;
  logic short_press;
  logic long_press;
  logic debounced_level;

  modport source (output valid, short_press, long_press, debounced_level, input ready);
  modport sink (input valid, short_press, long_press, debounced_level, output ready);
endinterface

>>> sv/bdsl_cfg.sv
module bdsl_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bdsl_pkg::CFG_AW-1:0]  paddr,
  input  logic [bdsl_pkg::CFG_DW-1:0]  pwdata,
  output logic [bdsl_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output bdsl_pkg::bdsl_cfg_t          cfg
);

  bdsl_pkg::bdsl_cfg_t            cfg_r;
  logic                           wr_en;
  logic [bdsl_pkg::IDX_W-1:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[bdsl_pkg::CFG_AW-1:2];
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window        <= bdsl_pkg::DEF_WINDOW;
      cfg_r.long_time     <= bdsl_pkg::DEF_LONG;
      cfg_r.pressed_level <= bdsl_pkg::DEF_PRESSED;
    end else if (wr_en) begin
      unique case (idx)
        bdsl_pkg::REG_WINDOW:  cfg_r.window        <= pwdata[bdsl_pkg::THR_W-1:0];
        bdsl_pkg::REG_LONG:    cfg_r.long_time     <= pwdata[bdsl_pkg::THR_W-1:0];
        bdsl_pkg::REG_PRESSED: cfg_r.pressed_level <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    unique case (idx)
      bdsl_pkg::REG_WINDOW:  prdata[bdsl_pkg::THR_W-1:0] = cfg_r.window;
      bdsl_pkg::REG_LONG:    prdata[bdsl_pkg::THR_W-1:0] = cfg_r.long_time;
      bdsl_pkg::REG_PRESSED: prdata[0] = cfg_r.pressed_level;
      default:               prdata = '0;
    endcase
  end

endmodule

>>> sv/bdsl_core.sv
module bdsl_core (
  input  logic                clk,
  input  logic                rst_n,
  input  bdsl_pkg::bdsl_cfg_t cfg,
  bdsl_in_if.sink             in_ch,
  bdsl_out_if.source          out_ch,
  output bdsl_pkg::bdsl_stat_t stat
);

  // input stage
  logic                          s1_valid_r;
  logic                          s1_raw_r;
  logic [bdsl_pkg::TIME_W-1:0]   s1_now_r;
  logic                          s1_seed_r;
  logic                          s1_cs_r;
  logic                          s1_cl_r;

  // result stage
  logic out_valid_r;
  logic out_short_r;
  logic out_long_r;
  logic out_level_r;

  // debounce state
  logic                        armed_r, armed_nxt;
  logic                        prev_r, prev_nxt;
  logic                        acc_r, acc_nxt;
  logic [bdsl_pkg::TIME_W-1:0] chg_r, chg_nxt;
  logic [bdsl_pkg::TIME_W-1:0] hold_r, hold_nxt;
  logic                        ldone_r, ldone_nxt;
  logic                        llatch_r, llatch_nxt;
  logic                        slatch_r, slatch_nxt;

  logic                        out_adv;
  logic                        step;
  logic [bdsl_pkg::TIME_W-1:0] diff_chg;
  logic [bdsl_pkg::TIME_W-1:0] diff_hold;
  logic [bdsl_pkg::TIME_W-1:0] win_ext;
  logic [bdsl_pkg::TIME_W-1:0] long_ext;
  logic                        short_o;
  logic                        long_o;

  // handshake: the result register parts the two sides
  assign out_adv     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || out_adv;
  assign step        = s1_valid_r && out_adv;

  assign win_ext  = {{(bdsl_pkg::TIME_W - bdsl_pkg::THR_W){1'b0}}, cfg.window};
  assign long_ext = {{(bdsl_pkg::TIME_W - bdsl_pkg::THR_W){1'b0}}, cfg.long_time};

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_raw_r  <= in_ch.raw_level;
      s1_now_r  <= in_ch.now_ms[bdsl_pkg::TIME_W-1:0];
      s1_seed_r <= in_ch.seed;
      s1_cs_r   <= in_ch.consume_short;
      s1_cl_r   <= in_ch.consume_long;
    end
  end

  // one poll: seed, debounce, hold timing, then consume
  always_comb begin
    armed_nxt  = armed_r;
    prev_nxt   = prev_r;
    acc_nxt    = acc_r;
    chg_nxt    = chg_r;
    hold_nxt   = hold_r;
    ldone_nxt  = ldone_r;
    llatch_nxt = llatch_r;
    slatch_nxt = slatch_r;
    diff_chg   = '0;
    diff_hold  = '0;
    if (s1_seed_r) begin
      prev_nxt   = s1_raw_r;
      acc_nxt    = s1_raw_r;
      chg_nxt    = '0;
      hold_nxt   = '0;
      ldone_nxt  = (s1_raw_r == cfg.pressed_level);
      llatch_nxt = 1'b0;
      slatch_nxt = 1'b0;
      armed_nxt  = 1'b1;
    end else if (armed_r) begin
      // raw change restarts the stability timer
      if (s1_raw_r != prev_r) begin
        prev_nxt = s1_raw_r;
        chg_nxt  = s1_now_r;
      end
      diff_chg = s1_now_r - chg_nxt;
      if (diff_chg >= win_ext && s1_raw_r != acc_r) begin
        acc_nxt = s1_raw_r;
        if (s1_raw_r == cfg.pressed_level) begin
          hold_nxt  = s1_now_r;
          ldone_nxt = 1'b0;
        end else if (!ldone_r) begin
          slatch_nxt = 1'b1;
        end
      end
      // long press fires once per hold
      diff_hold = s1_now_r - hold_nxt;
      if (acc_nxt == cfg.pressed_level && !ldone_nxt && diff_hold >= long_ext) begin
        llatch_nxt = 1'b1;
        ldone_nxt  = 1'b1;
      end
    end
    short_o = s1_cs_r & slatch_nxt;
    long_o  = s1_cl_r & llatch_nxt;
    if (s1_cs_r) begin
      slatch_nxt = 1'b0;
    end
    if (s1_cl_r) begin
      llatch_nxt = 1'b0;
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= 1'b0;
      prev_r   <= 1'b0;
      acc_r    <= 1'b0;
      chg_r    <= '0;
      hold_r   <= '0;
      ldone_r  <= 1'b0;
      llatch_r <= 1'b0;
      slatch_r <= 1'b0;
    end else if (step) begin
      armed_r  <= armed_nxt;
      prev_r   <= prev_nxt;
      acc_r    <= acc_nxt;
      chg_r    <= chg_nxt;
      hold_r   <= hold_nxt;
      ldone_r  <= ldone_nxt;
      llatch_r <= llatch_nxt;
      slatch_r <= slatch_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_short_r <= short_o;
      out_long_r  <= long_o;
      out_level_r <= acc_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.short_press     = out_short_r;
  assign out_ch.long_press      = out_long_r;
  assign out_ch.debounced_level = out_level_r;

  assign stat.stage_full  = s1_valid_r;
  assign stat.armed       = armed_r;
  assign stat.short_latch = slatch_r;
  assign stat.long_latch  = llatch_r;

endmodule

>>> sv/button_debounce_short_long_press.sv
// an accepted item goes through the input register, then the result register
// throughput: one item per cycle unless stalled; debounce is one logic pass per item
// a stalled result register holds the item; the input stage still fills behind it
// reset (synchronous, rst_n low): channels empty, block unarmed, registers at defaults
`include "assert_macros.svh"

module button_debounce_short_long_press (
  input  logic                         clk,
  input  logic                         rst_n,
  bdsl_in_if.sink                      in_ch,
  bdsl_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [bdsl_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [bdsl_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [bdsl_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  bdsl_pkg::bdsl_cfg_t  cfg;
  bdsl_pkg::bdsl_stat_t stat;

  // configuration registers
  bdsl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // debounce and press detection
  bdsl_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .stat   (stat)
  );

  // checks
  `BDSL_ASSERT(a_unarmed_no_latch, clk, rst_n, !stat.armed |-> (!stat.short_latch && !stat.long_latch))
  `BDSL_ASSERT(a_full_stall_blocks, clk, rst_n, (stat.stage_full && out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
  `BDSL_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> (!out_ch.valid && !stat.armed && !stat.stage_full))

endmodule

>>> sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  // one poll of the button and the result it produces
  typedef struct packed {
    logic                       raw_level;
    logic [bdsl_pkg::NOW_W-1:0] now_ms;
    logic                       seed;
    logic                       consume_short;
    logic                       consume_long;
  } poll_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic debounced_level;
  } press_t;

  logic clk;
  logic rst_n;
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [bdsl_pkg::CFG_AW-1:0] cfg_paddr;
  logic [bdsl_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [bdsl_pkg::CFG_DW-1:0] cfg_prdata;
  logic                        cfg_pready;

  bdsl_in_if  in_bus ();
  bdsl_out_if out_bus ();

  button_debounce_short_long_press uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus.sink),
    .out_ch      (out_bus.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // pending polls and expected presses
  poll_t  poll_q[$];
  press_t press_q[$];
  int     sent_cnt  = 0;
  int     taken_cnt = 0;
  int     err_cnt   = 0;
  int     cycle_cnt = 0;
  int     hold_cnt  = 0;
  bit     stall_done = 0;

  // register copies
  logic [bdsl_pkg::THR_W-1:0] win_ms    = bdsl_pkg::DEF_WINDOW;
  logic [bdsl_pkg::THR_W-1:0] long_ms   = bdsl_pkg::DEF_LONG;
  logic                       press_lvl = bdsl_pkg::DEF_PRESSED;

  // button state copies
  logic                        btn_armed   = 1'b0;
  logic                        last_raw    = 1'b0;
  logic                        settled     = 1'b0;
  logic [bdsl_pkg::TIME_W-1:0] change_at   = '0;
  logic [bdsl_pkg::TIME_W-1:0] hold_at     = '0;
  logic                        long_done   = 1'b0;
  logic                        long_latch  = 1'b0;
  logic                        short_latch = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // debounce and press detection for one poll
  function automatic press_t debounce_poll(poll_t p);
    press_t                      r;
    logic [bdsl_pkg::TIME_W-1:0] now;
    logic [bdsl_pkg::TIME_W-1:0] since;
    now = p.now_ms;
    if (p.seed) begin
      last_raw    = p.raw_level;
      settled     = p.raw_level;
      change_at   = '0;
      hold_at     = '0;
      long_done   = (p.raw_level == press_lvl);
      long_latch  = 1'b0;
      short_latch = 1'b0;
      btn_armed   = 1'b1;
    end else if (btn_armed) begin
      if (p.raw_level != last_raw) begin
        last_raw  = p.raw_level;
        change_at = now;
      end
      since = now - change_at;
      if (since >= win_ms && p.raw_level != settled) begin
        settled = p.raw_level;
        if (settled == press_lvl) begin
          hold_at   = now;
          long_done = 1'b0;
        end else if (!long_done) begin
          short_latch = 1'b1;
        end
      end
      since = now - hold_at;
      if (settled == press_lvl && !long_done && since >= long_ms) begin
        long_latch = 1'b1;
        long_done  = 1'b1;
      end
    end
    r.short_press = p.consume_short ? short_latch : 1'b0;
    r.long_press  = p.consume_long ? long_latch : 1'b0;
    if (p.consume_short) short_latch = 1'b0;
    if (p.consume_long) long_latch = 1'b0;
    r.debounced_level = settled;
    return r;
  endfunction

  function automatic void compare_field(string fname, logic want, logic got);
    if (want !== got) begin
      $error("%s mismatch: expected %0b, got %0b", fname, want, got);
      err_cnt++;
    end
  endfunction

  // driver: offers queued polls, predicts each accepted item
  always @(posedge clk) begin : drive_polls
    poll_t  nxt;
    poll_t  took;
    bit     calm;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        took.raw_level     = in_bus.raw_level;
        took.now_ms        = in_bus.now_ms;
        took.seed          = in_bus.seed;
        took.consume_short = in_bus.consume_short;
        took.consume_long  = in_bus.consume_long;
        press_q.push_back(debounce_poll(took));
        sent_cnt++;
      end
      calm = (sent_cnt >= 280 && sent_cnt < 360);
      if (!in_bus.valid || in_bus.ready) begin
        if (poll_q.size() != 0 && (calm || $urandom_range(0, 99) >= 38)) begin
          nxt = poll_q.pop_front();
          in_bus.raw_level     <= nxt.raw_level;
          in_bus.now_ms        <= nxt.now_ms;
          in_bus.seed          <= nxt.seed;
          in_bus.consume_short <= nxt.consume_short;
          in_bus.consume_long  <= nxt.consume_long;
          in_bus.valid         <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result item against the oldest expectation
  always @(posedge clk) begin : check_presses
    press_t want;
    logic   rdy;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (press_q.size() == 0) begin
          $error("result item with no poll pending");
          err_cnt++;
        end else begin
          want = press_q.pop_front();
          compare_field("short_press", want.short_press, out_bus.short_press);
          compare_field("long_press", want.long_press, out_bus.long_press);
          compare_field("debounced_level", want.debounced_level, out_bus.debounced_level);
        end
        taken_cnt++;
      end
      // one long hold-off so the block backs up into its input
      if (!stall_done && taken_cnt >= 150) begin
        hold_cnt   = 70;
        stall_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rdy = 1'b0;
      end else if (taken_cnt >= 280 && taken_cnt < 360) begin
        rdy = 1'b1;
      end else begin
        rdy = ($urandom_range(0, 99) >= 38);
      end
      out_bus.ready <= rdy;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_poll(logic raw, logic [bdsl_pkg::NOW_W-1:0] now, logic seed, logic cs,
                          logic cl);
    poll_t p;
    p.raw_level     = raw;
    p.now_ms        = now;
    p.seed          = seed;
    p.consume_short = cs;
    p.consume_long  = cl;
    poll_q.push_back(p);
  endtask

  // apb write, register copy follows at the access edge
  task automatic cfg_write(logic [bdsl_pkg::IDX_W-1:0] idx, logic [bdsl_pkg::CFG_DW-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      bdsl_pkg::REG_WINDOW:  win_ms    = val[bdsl_pkg::THR_W-1:0];
      bdsl_pkg::REG_LONG:    long_ms   = val[bdsl_pkg::THR_W-1:0];
      bdsl_pkg::REG_PRESSED: press_lvl = val[0];
      default: ;
    endcase
  endtask

  // wait until every poll has been taken and every result has come back
  task automatic wait_drained();
    while (poll_q.size() != 0 || in_bus.valid || press_q.size() != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  // mostly press and release runs with bounces, some seeds and some noise
  task automatic queue_random_polls(int n);
    logic [bdsl_pkg::NOW_W-1:0] t;
    logic                       lvl;
    logic                       raw;
    int                         run;
    int                         scale;
    int                         sel;
    int                         k;
    t     = $urandom;
    lvl   = 1'($urandom_range(0, 1));
    scale = (int'(win_ms) + int'(long_ms)) / 8 + 2;
    add_poll(lvl, t, 1'b1, 1'b0, 1'b0);
    k = 1;
    while (k < n) begin
      run = $urandom_range(1, 20);
      for (int j = 0; j < run && k < n; j++) begin
        sel = $urandom_range(0, 99);
        if (sel < 3) begin
          add_poll(1'($urandom_range(0, 1)), $urandom, 1'b0, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        end else if (sel < 5) begin
          add_poll(1'($urandom_range(0, 1)), t, 1'b1, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        end else begin
          t  += $urandom_range(0, scale);
          raw = (sel < 13) ? ~lvl : lvl;
          add_poll(raw, t, 1'b0, $urandom_range(0, 99) < 30, $urandom_range(0, 99) < 30);
        end
        k++;
      end
      lvl = ~lvl;
    end
    wait_drained();
  endtask

  // stimulus
  initial begin
    rst_n                = 1'b0;
    cfg_psel             = 1'b0;
    cfg_penable          = 1'b0;
    cfg_pwrite           = 1'b0;
    cfg_paddr            = '0;
    cfg_pwdata           = '0;
    in_bus.valid         = 1'b0;
    in_bus.raw_level     = 1'b0;
    in_bus.now_ms        = '0;
    in_bus.seed          = 1'b0;
    in_bus.consume_short = 1'b0;
    in_bus.consume_long  = 1'b0;
    out_bus.ready        = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset settings: active low, 25 ms window, 1000 ms long press
    add_poll(1'b1, 32'd5, 1'b0, 1'b1, 1'b1);     // unarmed poll is ignored
    add_poll(1'b1, 32'd100, 1'b1, 1'b1, 1'b1);   // seed released
    add_poll(1'b0, 32'd110, 1'b0, 1'b0, 1'b0);
    add_poll(1'b0, 32'd140, 1'b0, 1'b0, 1'b0);   // press accepted
    add_poll(1'b1, 32'd150, 1'b0, 1'b0, 1'b0);   // bounce
    add_poll(1'b0, 32'd160, 1'b0, 1'b0, 1'b0);
    add_poll(1'b1, 32'd200, 1'b0, 1'b0, 1'b0);
    add_poll(1'b1, 32'd230, 1'b0, 1'b0, 1'b1);   // short latched, not read
    add_poll(1'b1, 32'd231, 1'b0, 1'b1, 1'b0);   // short read out
    add_poll(1'b0, 32'd300, 1'b0, 1'b0, 1'b0);
    add_poll(1'b0, 32'd330, 1'b0, 1'b0, 1'b0);
    add_poll(1'b0, 32'd1329, 1'b0, 1'b0, 1'b1);  // one ms short of long
    add_poll(1'b0, 32'd1330, 1'b0, 1'b0, 1'b0);  // long latched while held
    add_poll(1'b0, 32'd1400, 1'b0, 1'b1, 1'b1);
    add_poll(1'b1, 32'd1500, 1'b0, 1'b0, 1'b0);
    add_poll(1'b1, 32'd1530, 1'b0, 1'b1, 1'b0);  // release after long: no short
    add_poll(1'b0, 32'd2000, 1'b1, 1'b1, 1'b1);  // seed while held retires the hold
    add_poll(1'b1, 32'd2010, 1'b0, 1'b0, 1'b0);
    add_poll(1'b1, 32'd2040, 1'b0, 1'b1, 1'b1);
    add_poll(1'b0, 32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0);
    add_poll(1'b0, 32'h0000_0010, 1'b0, 1'b0, 1'b0); // accepted across the time wrap
    add_poll(1'b1, 32'h0000_0020, 1'b0, 1'b0, 1'b0);
    add_poll(1'b1, 32'h0000_0040, 1'b0, 1'b1, 1'b0);
    add_poll(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    add_poll(1'b0, 32'h0000_0000, 1'b0, 1'b1, 1'b1);
    wait_drained();

    // zero thresholds, active high
    cfg_write(bdsl_pkg::REG_WINDOW, 32'd0);
    cfg_write(bdsl_pkg::REG_LONG, 32'd0);
    cfg_write(bdsl_pkg::REG_PRESSED, 32'd1);
    queue_random_polls(100);

    // largest thresholds, active low
    cfg_write(bdsl_pkg::REG_WINDOW, 32'd65535);
    cfg_write(bdsl_pkg::REG_LONG, 32'd65535);
    cfg_write(bdsl_pkg::REG_PRESSED, 32'd0);
    queue_random_polls(100);

    // short thresholds, active high
    cfg_write(bdsl_pkg::REG_WINDOW, 32'd10);
    cfg_write(bdsl_pkg::REG_LONG, 32'd120);
    cfg_write(bdsl_pkg::REG_PRESSED, 32'd1);
    queue_random_polls(130);

    // back to the usual button timing
    cfg_write(bdsl_pkg::REG_WINDOW, {16'd0, bdsl_pkg::DEF_WINDOW});
    cfg_write(bdsl_pkg::REG_LONG, {16'd0, bdsl_pkg::DEF_LONG});
    cfg_write(bdsl_pkg::REG_PRESSED, 32'd0);
    queue_random_polls(120);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
